@@ rtl/core/hrac_pkg.sv @@
// Shared constants and types for the hexagon right-angle check.
`default_nettype none

package hrac_pkg;

  // Default coordinate width in bits
  localparam int COORD_BITS_DEF = 12;

  // Vertices and corners of the polygon
  localparam int NUM_VERTS = 6;

  // Register stages from input beat to output register
  localparam int PIPE_DEPTH = 7;

  // Load enables for the per-corner stages
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } hrac_ld_t;

endpackage

`default_nettype wire

@@ rtl/core/hrac_corner.sv @@
// Per-corner cosine test: scaled dot square against product of squared edge lengths.
`default_nettype none

module hrac_corner #(
  parameter int COORD_BITS = hrac_pkg::COORD_BITS_DEF
) (
  input  wire                      clk,
  input  wire hrac_pkg::hrac_ld_t  ld,
  input  wire signed [2*COORD_BITS+2:0] dot,
  input  wire [2*COORD_BITS+1:0]   len_prev,
  input  wire [2*COORD_BITS+1:0]   len_cur,
  output logic                     pass
);

  localparam int SW  = 2 * COORD_BITS + 2;   // squared length, |dot|
  localparam int DW  = SW + 1;               // signed dot
  localparam int AW  = SW + 3;               // 5 * |dot|
  localparam int ALO = AW / 2;
  localparam int AHI = AW - ALO;
  localparam int RLO = SW / 2;
  localparam int RHI = SW - RLO;
  localparam int PL  = 2 * AW;
  localparam int PR  = 2 * SW;

  logic [SW-1:0]      dot_abs;
  logic [AW-1:0]      a5_next;
  logic [AW-1:0]      a5;
  logic [SW-1:0]      lp4;
  logic [SW-1:0]      lc4;
  logic [AW+ALO-1:0]  pl_lo;
  logic [AW+AHI-1:0]  pl_hi;
  logic [SW+RLO-1:0]  pr_lo;
  logic [SW+RHI-1:0]  pr_hi;
  logic [PL-1:0]      lhs;
  logic [PR-1:0]      rhs;

  // Magnitude of the dot product, scaled by five
  assign dot_abs = SW'(dot[DW-1] ? (~dot + DW'(1)) : dot);
  assign a5_next = (AW'(dot_abs) << 2) + AW'(dot_abs);

  // Stage 4: hold scaled magnitude and both lengths
  always_ff @(posedge clk) begin
    if (ld.s4) begin
      a5  <= a5_next;
      lp4 <= len_prev;
      lc4 <= len_cur;
    end
  end

  // Stage 5: split each product into two narrower partial products
  always_ff @(posedge clk) begin
    if (ld.s5) begin
      pl_lo <= (AW+ALO)'(a5) * (AW+ALO)'(a5[ALO-1:0]);
      pl_hi <= (AW+AHI)'(a5) * (AW+AHI)'(a5[AW-1:ALO]);
      pr_lo <= (SW+RLO)'(lp4) * (SW+RLO)'(lc4[RLO-1:0]);
      pr_hi <= (SW+RHI)'(lp4) * (SW+RHI)'(lc4[SW-1:RLO]);
    end
  end

  // Stage 6: recombine the partial products
  always_ff @(posedge clk) begin
    if (ld.s6) begin
      lhs <= (PL'(pl_hi) << ALO) + PL'(pl_lo);
      rhs <= (PR'(pr_hi) << RLO) + PR'(pr_lo);
    end
  end

  // Stage 7: pass when 25*dot^2 does not exceed |u|^2*|v|^2
  always_ff @(posedge clk) begin
    if (ld.s7) begin
      pass <= (lhs <= PL'(rhs));
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hexagon_right_angle_check.sv @@
// Top level of the hexagon right-angle check pipeline.
//
// Usage: present the six vertices (x, y per vertex) on the input channel with
// in_valid; a beat is taken on a rising edge where in_valid is high and
// in_stall is low. Each beat yields exactly one output beat carrying
// corner_mask (bit k set when the corner at vertex k has |cos| <= 0.2) and
// all_square (all six corners pass), taken where out_valid is high and
// out_stall is low.
// Throughput is one beat per cycle while out_stall is low, through seven
// register stages (edges, products, sums, scaling, split squares,
// recombine, compare); a stage loads when it is empty or its beat moves on.
// When the receiver stalls, the output register holds its beat and stages
// behind it keep filling until every stage holds a beat; only then is
// in_stall raised. Nothing is dropped or repeated.
// Reset clears all valid bits and holds in_stall high; once rst falls the
// block accepts a beat at once.
`default_nettype none

module hexagon_right_angle_check #(
  parameter int COORD_BITS = hrac_pkg::COORD_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire [COORD_BITS-1:0]  v0_x,
  input  wire [COORD_BITS-1:0]  v0_y,
  input  wire [COORD_BITS-1:0]  v1_x,
  input  wire [COORD_BITS-1:0]  v1_y,
  input  wire [COORD_BITS-1:0]  v2_x,
  input  wire [COORD_BITS-1:0]  v2_y,
  input  wire [COORD_BITS-1:0]  v3_x,
  input  wire [COORD_BITS-1:0]  v3_y,
  input  wire [COORD_BITS-1:0]  v4_x,
  input  wire [COORD_BITS-1:0]  v4_y,
  input  wire [COORD_BITS-1:0]  v5_x,
  input  wire [COORD_BITS-1:0]  v5_y,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  all_square,
  output logic [5:0]            corner_mask
);

  localparam int NV    = hrac_pkg::NUM_VERTS;
  localparam int DEPTH = hrac_pkg::PIPE_DEPTH;
  localparam int EW    = COORD_BITS + 1;      // signed edge component
  localparam int PW    = 2 * EW;              // signed component product
  localparam int SW    = 2 * COORD_BITS + 2;  // squared length
  localparam int DW    = SW + 1;              // signed dot

  logic [COORD_BITS-1:0] px [NV];
  logic [COORD_BITS-1:0] py [NV];

  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] ld;

  logic signed [EW-1:0] ex  [NV];
  logic signed [EW-1:0] ey  [NV];
  logic [PW-2:0]        sqx [NV];
  logic [PW-2:0]        sqy [NV];
  logic signed [PW-1:0] dpx [NV];
  logic signed [PW-1:0] dpy [NV];
  logic [SW-1:0]        len [NV];
  logic signed [DW-1:0] dot [NV];
  logic [NV-1:0]        pass;

  hrac_pkg::hrac_ld_t   cld;

  assign px[0] = v0_x;  assign py[0] = v0_y;
  assign px[1] = v1_x;  assign py[1] = v1_y;
  assign px[2] = v2_x;  assign py[2] = v2_y;
  assign px[3] = v3_x;  assign py[3] = v3_y;
  assign px[4] = v4_x;  assign py[4] = v4_y;
  assign px[5] = v5_x;  assign py[5] = v5_y;

  // Load a stage when it is empty or its beat moves on
  always_comb begin
    ld[DEPTH-1] = !vld[DEPTH-1] || !out_stall;
    for (int i = DEPTH - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  // Hold off the sender during reset and while the pipeline is full and the output is stalled
  assign in_stall = rst || !ld[0];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign cld.s4 = ld[3];
  assign cld.s5 = ld[4];
  assign cld.s6 = ld[5];
  assign cld.s7 = ld[6];

  for (genvar k = 0; k < NV; k++) begin : g_lane
    localparam int NX = (k + 1) % NV;
    localparam int PV = (k + NV - 1) % NV;

    // Stage 1: edge k runs from vertex k to the next vertex
    always_ff @(posedge clk) begin
      if (ld[0]) begin
        ex[k] <= $signed({1'b0, px[NX]}) - $signed({1'b0, px[k]});
        ey[k] <= $signed({1'b0, py[NX]}) - $signed({1'b0, py[k]});
      end
    end

    // Stage 2: component squares and products with the previous edge
    always_ff @(posedge clk) begin
      if (ld[1]) begin
        sqx[k] <= (PW-1)'(ex[k] * ex[k]);
        sqy[k] <= (PW-1)'(ey[k] * ey[k]);
        dpx[k] <= ex[PV] * ex[k];
        dpy[k] <= ey[PV] * ey[k];
      end
    end

    // Stage 3: squared length of edge k and dot at corner k
    always_ff @(posedge clk) begin
      if (ld[2]) begin
        len[k] <= SW'(sqx[k]) + SW'(sqy[k]);
        dot[k] <= DW'(dpx[k]) + DW'(dpy[k]);
      end
    end

    hrac_corner #(
      .COORD_BITS (COORD_BITS)
    ) u_corner (
      .clk      (clk),
      .ld       (cld),
      .dot      (dot[k]),
      .len_prev (len[PV]),
      .len_cur  (len[k]),
      .pass     (pass[k])
    );
  end

  assign out_valid   = vld[DEPTH-1];
  assign corner_mask = pass;
  assign all_square  = &pass;

endmodule

`default_nettype wire

@@ tb/sv/hexagon_right_angle_check_test.sv @@
// Self-checking testbench for the hexagon right-angle check pipeline.
`default_nettype none

module hexagon_right_angle_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = hrac_pkg::COORD_BITS_DEF;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_LIMIT = 20000;
  // |cos| <= 0.2 becomes 25 * dot^2 <= |u|^2 * |v|^2
  localparam int COS_LIMIT_INV_SQ = 25;

  typedef struct packed {
    logic [5:0][COORD_W-1:0] x;
    logic [5:0][COORD_W-1:0] y;
  } hexagon_t;

  typedef struct {
    logic       all_square;
    logic [5:0] corner_mask;
  } verdict_t;

  // Predict the corner verdicts and match them against the output beats
  class corner_scoreboard;
    verdict_t expected_q[$];
    int errors = 0;

    function bit corner_is_square(longint ux, longint uy, longint vx, longint vy);
      longint dot;
      bit [127:0] adot, len_u, len_v;
      dot = ux * vx + uy * vy;
      adot = (dot < 0) ? -dot : dot;
      len_u = ux * ux + uy * uy;
      len_v = vx * vx + vy * vy;
      return (adot * adot * COS_LIMIT_INV_SQ) <= (len_u * len_v);
    endfunction

    function void note_hexagon(hexagon_t h);
      longint px[6], py[6];
      bit [5:0] mask;
      int prv, nxt;
      verdict_t v;
      for (int k = 0; k < 6; k++) begin
        px[k] = h.x[k];
        py[k] = h.y[k];
      end
      mask = '0;
      // wrap neighbors around the closed polygon
      for (int k = 0; k < 6; k++) begin
        prv = (k + 5) % 6;
        nxt = (k + 1) % 6;
        mask[k] = corner_is_square(px[prv] - px[k], py[prv] - py[k],
                                   px[nxt] - px[k], py[nxt] - py[k]);
      end
      v.corner_mask = mask;
      v.all_square = (mask == 6'h3F);
      expected_q.insert(expected_q.size(), v);
    endfunction

    function void check_verdict(logic all_sq, logic [5:0] mask);
      verdict_t v;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat all_square=%b corner_mask=%b",
                 $time, all_sq, mask);
        errors++;
        return;
      end
      v = expected_q.pop_front();
      if (mask !== v.corner_mask) begin
        $display("%0t: corner_mask expected %b got %b", $time, v.corner_mask, mask);
        errors++;
      end
      if (all_sq !== v.all_square) begin
        $display("%0t: all_square expected %b got %b", $time, v.all_square, all_sq);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  hexagon_t drive_h = '0;
  logic in_stall, out_valid, all_square;
  logic [5:0] corner_mask;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_request = 1'b0;
  int accepted_count = 0;
  corner_scoreboard sb = new;

  hexagon_right_angle_check uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .v0_x        (drive_h.x[0]),
    .v0_y        (drive_h.y[0]),
    .v1_x        (drive_h.x[1]),
    .v1_y        (drive_h.y[1]),
    .v2_x        (drive_h.x[2]),
    .v2_y        (drive_h.y[2]),
    .v3_x        (drive_h.x[3]),
    .v3_y        (drive_h.y[3]),
    .v4_x        (drive_h.x[4]),
    .v4_y        (drive_h.y[4]),
    .v5_x        (drive_h.x[5]),
    .v5_y        (drive_h.y[5]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .all_square  (all_square),
    .corner_mask (corner_mask)
  );

  always #5 clk = ~clk;

  // Record accepted input beats and check accepted output beats
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_hexagon(drive_h);
      accepted_count <= accepted_count + 1;
    end
    if (!rst && out_valid && !out_stall)
      sb.check_verdict(all_square, corner_mask);
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Bound the run
  initial begin
    #(5_000_000);
    $display("hexagon_right_angle_check regression: fail");
    $finish;
  end

  function automatic hexagon_t to_hexagon(input int px[6], input int py[6]);
    hexagon_t h;
    for (int k = 0; k < 6; k++) begin
      h.x[k] = (px[k] < 0) ? '0 : (px[k] > COORD_MAX) ? '1 : px[k][COORD_W-1:0];
      h.y[k] = (py[k] < 0) ? '0 : (py[k] > COORD_MAX) ? '1 : py[k][COORD_W-1:0];
    end
    return h;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return COORD_MAX;
      2: return 1;
      3: return COORD_MAX - 1;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  // Build a random polygon: mostly L shapes with exact or near right angles
  function automatic hexagon_t make_hexagon();
    int px[6], py[6], qx[6], qy[6], fs[6], ft[6];
    int pick, span, tmp, jit, a, b, rot, idx;
    int xa, xb, xc, ya, yb, yc, len_s, mid_s, len_t, mid_t;
    bit rev;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // uniform noise
      for (int k = 0; k < 6; k++) begin
        px[k] = $urandom_range(0, COORD_MAX);
        py[k] = $urandom_range(0, COORD_MAX);
      end
    end else if (pick < 27) begin
      // coordinates mostly at or next to the range ends
      for (int k = 0; k < 6; k++) begin
        px[k] = extreme_coord();
        py[k] = extreme_coord();
      end
    end else if (pick < 52) begin
      // L shape in a frame rotated along a lattice direction
      a = $urandom_range(1, 7);
      b = $urandom_range(0, 7);
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
      len_s = $urandom_range(2, 120);
      mid_s = $urandom_range(1, len_s - 1);
      len_t = $urandom_range(2, 120);
      mid_t = $urandom_range(1, len_t - 1);
      fs = '{0, len_s, len_s, mid_s, mid_s, 0};
      ft = '{0, 0, mid_t, mid_t, len_t, len_t};
      for (int k = 0; k < 6; k++) begin
        px[k] = 2048 + fs[k] * a - ft[k] * b;
        py[k] = 2048 + fs[k] * b + ft[k] * a;
      end
    end else begin
      // axis-aligned L shape, small or large
      span = ($urandom_range(0, 3) == 0) ? 40 : 1300;
      xa = $urandom_range(0, COORD_MAX - 2 * span);
      xb = xa + $urandom_range(1, span);
      xc = xb + $urandom_range(1, span);
      ya = $urandom_range(0, COORD_MAX - 2 * span);
      yb = ya + $urandom_range(1, span);
      yc = yb + $urandom_range(1, span);
      px = '{xa, xc, xc, xb, xb, xa};
      py = '{ya, ya, yb, yb, yc, yc};
      if ($urandom_range(0, 1))
        for (int k = 0; k < 6; k++) px[k] = COORD_MAX - px[k];
      if ($urandom_range(0, 1))
        for (int k = 0; k < 6; k++) py[k] = COORD_MAX - py[k];
      if ($urandom_range(0, 1))
        for (int k = 0; k < 6; k++) begin
          tmp = px[k];
          px[k] = py[k];
          py[k] = tmp;
        end
      // collapse a randomly chosen edge to zero length, sometimes another as well
      if (pick >= 85)
        repeat ($urandom_range(1, 2)) begin
          idx = $urandom_range(0, 5);
          px[(idx + 1) % 6] = px[idx];
          py[(idx + 1) % 6] = py[idx];
        end
    end
    // jitter the vertices of clean shapes by a small random offset
    if (pick >= 27 && pick < 85 && $urandom_range(0, 1)) begin
      case ($urandom_range(0, 2))
        0: jit = 1;
        1: jit = 3;
        default: jit = 8;
      endcase
      for (int k = 0; k < 6; k++) begin
        px[k] = px[k] + int'($urandom_range(0, 2 * jit)) - jit;
        py[k] = py[k] + int'($urandom_range(0, 2 * jit)) - jit;
      end
    end
    // rotate the start vertex and maybe reverse the winding
    rot = $urandom_range(0, 5);
    rev = 1'($urandom_range(0, 1));
    for (int k = 0; k < 6; k++) begin
      idx = rev ? (rot + 6 - k) % 6 : (rot + k) % 6;
      qx[k] = px[idx];
      qy[k] = py[idx];
    end
    return to_hexagon(qx, qy);
  endfunction

  // Offer one beat, with an optional idle burst ahead of it
  task automatic send_hexagon(input hexagon_t h);
    int target;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    drive_h = h;
    target = accepted_count + 1;
    wait (accepted_count == target);
  endtask

  initial begin
    int cycles;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed polygons
    send_hexagon(to_hexagon('{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}));
    send_hexagon(to_hexagon('{4095, 4095, 4095, 4095, 4095, 4095},
                            '{4095, 4095, 4095, 4095, 4095, 4095}));
    send_hexagon(to_hexagon('{0, 4095, 4095, 2048, 2048, 0},
                            '{0, 0, 2048, 2048, 4095, 4095}));
    send_hexagon(to_hexagon('{0, 0, 2048, 2048, 4095, 4095},
                            '{0, 4095, 4095, 2048, 2048, 0}));
    send_hexagon(to_hexagon('{2000, 3000, 3500, 3000, 2000, 1500},
                            '{1000, 1000, 1866, 2732, 2732, 1866}));
    // corner 1 just inside and just outside the cosine limit
    send_hexagon(to_hexagon('{2000, 1000, 1200, 1500, 500, 300},
                            '{1000, 1000, 1980, 2500, 2500, 1500}));
    send_hexagon(to_hexagon('{2000, 1000, 1200, 1500, 500, 300},
                            '{1000, 1000, 1979, 2500, 2500, 1500}));
    // zero-length edge
    send_hexagon(to_hexagon('{0, 4095, 4095, 2048, 2048, 0},
                            '{0, 0, 0, 2048, 4095, 4095}));
    send_hexagon(to_hexagon('{0, 800, 1600, 2400, 3200, 4095},
                            '{0, 800, 1600, 2400, 3200, 4095}));
    send_hexagon(to_hexagon('{0, 4095, 0, 4095, 0, 4095},
                            '{0, 4095, 0, 4095, 0, 4095}));
    send_hexagon(to_hexagon('{0, 4095, 0, 4095, 0, 4095},
                            '{4095, 0, 4095, 0, 4095, 0}));
    send_hexagon(to_hexagon('{'hAAA, 'h555, 'hAAA, 'h555, 'hFFF, 0},
                            '{'h555, 'hAAA, 0, 'hFFF, 'h555, 'hAAA}));
    send_hexagon(to_hexagon('{0, 2, 2, 1, 1, 0}, '{0, 0, 1, 1, 2, 2}));
    send_hexagon(to_hexagon('{2048, 2348, 2148, 1998, 1798, 1648},
                            '{2048, 2448, 2598, 2398, 2548, 2348}));
    send_hexagon(to_hexagon('{5, 5, 5, 5, 5, 4000}, '{7, 7, 7, 7, 7, 9}));

    // random polygons with idling on both sides
    repeat (250) send_hexagon(make_hexagon());

    // hold the receiver off while beats keep coming, filling the pipeline
    tx_idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (30) send_hexagon(make_hexagon());
    tx_idle_on = 1'b1;

    // pause the sender until the pipeline drains
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    repeat (150) send_hexagon(make_hexagon());

    // full rate at the end
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (150) send_hexagon(make_hexagon());
    @(negedge clk);
    in_valid = 1'b0;

    cycles = 0;
    while (sb.pending() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    repeat (hrac_pkg::PIPE_DEPTH + 8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hexagon_right_angle_check regression: pass");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending());
      $display("hexagon_right_angle_check regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/hrac_pkg.sv
rtl/core/hrac_corner.sv
rtl/core/hexagon_right_angle_check.sv
tb/sv/hexagon_right_angle_check_test.sv
